### design/gbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Word layouts, store geometry, arithmetic widths and register indices.
// ----------------------------------------------------------------------------
package gbs_pkg;

	// Capacity of the kept-box store.
	localparam int MAX_KEPT = 256;
	localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W    = $clog2(MAX_KEPT + 1);

	// Field widths.
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;
	localparam int CLASS_W = 7;
	localparam int KEPT_W  = 9;
	localparam int THR_W   = 9;
	localparam int EDGE_W  = COORD_W + 1;
	localparam int AREA_W  = 2 * SIZE_W;
	localparam int UNI_W   = AREA_W + 1;
	localparam int SCALE_SHIFT = 8;
	localparam int PROD_W  = UNI_W + THR_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = THR_W;
	localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = CFG_IDX_W'(1);
	localparam logic [THR_W-1:0]     THR_RESET          = THR_W'(115);

	typedef struct packed {
		logic signed [COORD_W-1:0] box_x;
		logic signed [COORD_W-1:0] box_y;
		logic [SIZE_W-1:0]         box_w;
		logic [SIZE_W-1:0]         box_h;
		logic [CLASS_W-1:0]        class_id;
		logic                      set_end;
	} box_word_t;

	typedef struct packed {
		logic              kept;
		logic [KEPT_W-1:0] kept_total;
		logic              store_overflow;
		logic              result_end;
	} res_word_t;

	// One stored box, with its area worked out once.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic [CLASS_W-1:0]        cls;
		logic [AREA_W-1:0]         area;
	} entry_t;

	// Control travelling alongside an entry through the overlap pipeline.
	typedef struct packed {
		logic live;
		logic check;
		logic last;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_res_t;

endpackage : gbs_pkg
`default_nettype wire

### design/gbs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_cell: one slot of the kept-box ring
// Holds one stored box; either takes its neighbour's box or a new box.
// ----------------------------------------------------------------------------
module gbs_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire logic            load,
	input  wire gbs_pkg::entry_t shift_in,
	input  wire gbs_pkg::entry_t load_data,
	output gbs_pkg::entry_t      entry
);
	import gbs_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_data;
		end else if (shift) begin
			entry_q <= shift_in;
		end
	end

	assign entry = entry_q;

endmodule : gbs_cell
`default_nettype wire

### design/gbs_iou.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_iou: six-stage overlap test
// Compares the candidate with one stored box per cycle and flags a hit when
// intersection * 256 exceeds threshold * union.
// ----------------------------------------------------------------------------
module gbs_iou (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire gbs_pkg::entry_t           cand,
	input  wire gbs_pkg::entry_t           entry,
	input  wire gbs_pkg::scan_ctl_t        issue,
	input  wire logic [gbs_pkg::THR_W-1:0] thr,
	input  wire logic                      agnostic,
	output gbs_pkg::scan_res_t             result
);
	import gbs_pkg::*;

	scan_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	scan_res_t res_s6;

	logic signed [EDGE_W-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
	logic signed [EDGE_W-1:0] lox_s1, hix_s1, loy_s1, hiy_s1;
	logic [AREA_W-1:0]        areab_s1, areab_s2, areab_s3;
	logic signed [EDGE_W:0]   dx, dy;
	logic [SIZE_W-1:0]        ow_s2, oh_s2;
	logic [AREA_W-1:0]        inter_s3, inter_s4, inter_s5;
	logic [UNI_W-1:0]         uni_s4;
	logic [PROD_W-1:0]        prod_s5;
	logic                     class_ok;

	// Edges are formed exactly at one bit wider than the coordinates.
	always_comb begin
		ax0 = {cand.x[COORD_W-1], cand.x};
		ay0 = {cand.y[COORD_W-1], cand.y};
		bx0 = {entry.x[COORD_W-1], entry.x};
		by0 = {entry.y[COORD_W-1], entry.y};
		ax1 = ax0 + $signed({2'b00, cand.w});
		ay1 = ay0 + $signed({2'b00, cand.h});
		bx1 = bx0 + $signed({2'b00, entry.w});
		by1 = by0 + $signed({2'b00, entry.h});
		class_ok = agnostic || (cand.cls == entry.cls);
		dx = {hix_s1[EDGE_W-1], hix_s1} - {lox_s1[EDGE_W-1], lox_s1};
		dy = {hiy_s1[EDGE_W-1], hiy_s1} - {loy_s1[EDGE_W-1], loy_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			res_s6 <= '0;
		end else begin
			ctl_s1.live  <= issue.live;
			ctl_s1.check <= issue.live && issue.check && class_ok;
			ctl_s1.last  <= issue.last;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			ctl_s4       <= ctl_s3;
			ctl_s5       <= ctl_s4;
			res_s6.done  <= ctl_s5.live && ctl_s5.last;
			res_s6.hit   <= ctl_s5.live && ctl_s5.check &&
				(PROD_W'({inter_s5, SCALE_SHIFT'(0)}) > prod_s5);
		end
	end

	always_ff @(posedge clk) begin
		lox_s1   <= (ax0 > bx0) ? ax0 : bx0;
		hix_s1   <= (ax1 < bx1) ? ax1 : bx1;
		loy_s1   <= (ay0 > by0) ? ay0 : by0;
		hiy_s1   <= (ay1 < by1) ? ay1 : by1;
		areab_s1 <= entry.area;
		// A positive overlap never exceeds the candidate's own size.
		ow_s2    <= (dx > $signed((EDGE_W+1)'(0))) ? dx[SIZE_W-1:0] : '0;
		oh_s2    <= (dy > $signed((EDGE_W+1)'(0))) ? dy[SIZE_W-1:0] : '0;
		areab_s2 <= areab_s1;
		inter_s3 <= AREA_W'(ow_s2) * AREA_W'(oh_s2);
		areab_s3 <= areab_s2;
		uni_s4   <= UNI_W'(cand.area) + UNI_W'(areab_s3) - UNI_W'(inter_s3);
		inter_s4 <= inter_s3;
		prod_s5  <= PROD_W'(thr) * PROD_W'(uni_s4);
		inter_s5 <= inter_s4;
	end

	assign result = res_s6;

endmodule : gbs_iou
`default_nettype wire

### design/greedy_box_suppression_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_suppression_top: greedy non-maximum suppression by IoU
// Keeps score-sorted boxes whose overlap with every kept box of the same class
// (of any class when class-agnostic) stays within the threshold.
// ----------------------------------------------------------------------------
// Boxes are handled one at a time: the next box word is taken only once the
// previous box has made one full turn of the rotating ring of MAX_KEPT cells
// past the single six-stage overlap unit and its result has been committed.
// Reset: arst_n clears the kept count, the overflow flag, the control state and
// the registers (threshold 115, class-aware); stored boxes are not cleared.
module greedy_box_suppression_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           box_valid,
	output logic                                box_stall,
	input  wire gbs_pkg::box_word_t             box,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output gbs_pkg::res_word_t                  res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gbs_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q, scan_q, count_after;
	logic             ovf_q, ovf_after;
	logic             suppress_q;
	logic             end_q;
	entry_t           cand_q;
	logic [THR_W-1:0] thr_q;
	logic             agn_q;
	logic             res_valid_q;
	res_word_t        res_q;

	logic             accept, commit, keep, room, store_en, ring_shift;
	scan_ctl_t        issue;
	scan_res_t        iou_res;
	entry_t           ring [MAX_KEPT];
	logic [MAX_KEPT-1:0] load_vec;

	// Registers are written whenever offered; the user must change them only while idle (unenforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			agn_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IOU_THRESHOLD:  thr_q <= cfg_data;
				REG_CLASS_AGNOSTIC: agn_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A box word is taken only while the sequencer waits, so the result of the
	// previous box may still sit in the output register.
	assign box_stall = (state_q != S_IDLE);
	assign accept    = box_valid && !box_stall;

	// During the scan the head cell feeds the overlap unit and the ring turns
	// by one slot each cycle, so by the end of the scan it is back in place.
	// Slot j is compared while the scan index is j and counts only if it lies
	// below the kept count.
	assign ring_shift  = (state_q == S_SCAN);
	assign issue.live  = ring_shift;
	assign issue.check = (scan_q < count_q);
	assign issue.last  = (scan_q == CNT_W'(MAX_KEPT - 1));

	// The verdict is committed together with the output register load, so a
	// stalled result simply holds the sequencer in its final state.
	assign commit    = (state_q == S_FIN) && (!res_valid_q || !res_stall);
	assign keep      = !suppress_q;
	assign room      = (count_q < CNT_W'(MAX_KEPT));
	assign store_en  = commit && keep && room;
	assign count_after = store_en ? count_q + CNT_W'(1) : count_q;
	assign ovf_after   = ovf_q || (commit && keep && !room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			ovf_q       <= 1'b0;
			suppress_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					suppress_q <= 1'b0;
					scan_q     <= '0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					suppress_q <= suppress_q || iou_res.hit;
					if (issue.last) begin
						scan_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_DRAIN: begin
					suppress_q <= suppress_q || iou_res.hit;
					if (iou_res.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						// The last box of a set empties the store after its result.
						count_q <= end_q ? '0 : count_after;
						ovf_q   <= end_q ? 1'b0 : ovf_after;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Candidate and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q.x   <= box.box_x;
			cand_q.y   <= box.box_y;
			cand_q.w   <= box.box_w;
			cand_q.h   <= box.box_h;
			cand_q.cls <= box.class_id;
			end_q      <= box.set_end;
		end
		if (state_q == S_PREP) begin
			cand_q.area <= AREA_W'(cand_q.w) * AREA_W'(cand_q.h);
		end
		if (commit) begin
			res_q.kept           <= keep;
			res_q.kept_total     <= KEPT_W'(count_after);
			res_q.store_overflow <= ovf_after;
			res_q.result_end     <= end_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The ring of cells. Each cell hands its box to the one below it while the
	// ring turns; a newly kept box is written into the slot at the kept count.
	for (genvar k = 0; k < MAX_KEPT; k++) begin : g_ring
		assign load_vec[k] = store_en && (count_q[IDX_W-1:0] == IDX_W'(k));

		gbs_cell u_cell (
			.clk       (clk),
			.shift     (ring_shift),
			.load      (load_vec[k]),
			.shift_in  (ring[(k + 1) % MAX_KEPT]),
			.load_data (cand_q),
			.entry     (ring[k])
		);
	end

	gbs_iou u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.cand     (cand_q),
		.entry    (ring[0]),
		.issue    (issue),
		.thr      (thr_q),
		.agnostic (agn_q),
		.result   (iou_res)
	);

`ifndef SYNTHESIS
	// The kept count never passes the capacity of the ring.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("kept count beyond store capacity");

	// Overflow can only have been recorded with a full store.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(MAX_KEPT)))
		else $error("overflow flagged with room left in the store");

	// The end marker of a scan leaves the overlap unit only while draining.
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		iou_res.done |-> (state_q == S_DRAIN))
		else $error("scan end seen outside the drain phase");

	// A fresh result appears only from the commit of a finished scan.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result loaded without a committed verdict");
`endif

endmodule : greedy_box_suppression_top
`default_nettype wire

### sim/greedy_box_suppression_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_suppression_top_tb: self-checking bench for greedy box suppression
// Drives score-ordered box words through a short table of directed cases and
// then through random scenes under several threshold and class settings.
// Every result word is checked, field by field, against a behavioural model
// of the suppression that runs alongside the block, or a typed-in outcome.
// ----------------------------------------------------------------------------
module greedy_box_suppression_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gbs_pkg::*;

	// One box takes a full turn of the ring plus the overlap pipeline.
	localparam int BOX_LATENCY = MAX_KEPT + 9;
	// Cycles without any handshake before the run is declared hung.
	localparam int QUIET_LIMIT = 10 * BOX_LATENCY;
	// An index that names no register; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

	typedef enum logic {ROW_BOX, ROW_REG} row_kind_t;

	// One line of the directed script: either a box word or a register write.
	// Where the outcome is obvious it is typed in and checked as written.
	typedef struct {
		row_kind_t             kind;
		box_word_t             word;
		bit                    known;
		res_word_t             want;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} row_t;

	// A box as the model keeps it, with edges widened to plain integers.
	typedef struct {
		int             x;
		int             y;
		int             w;
		int             h;
		logic [CLASS_W-1:0] cls;
		longint         area;
	} held_box_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  box_valid = 1'b0;
	logic                  box_stall;
	box_word_t             box       = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_word_t             res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Model of the suppression: its own copy of the registers and the store.
	logic [THR_W-1:0] iou_limit = THR_RESET;
	logic             any_class = 1'b0;
	held_box_t        held[MAX_KEPT];
	int               held_count = 0;
	logic             store_full_seen = 1'b0;

	// Verdicts still owed by the block, oldest first.
	res_word_t verdicts[$];

	// The directed script, in the order it is played.
	row_t script[$];

	int idle_pct    = 31;
	int stall_pct   = 31;
	int fault_count = 0;
	int quiet_cycles = 0;
	int hub_x[4];
	int hub_y[4];

	greedy_box_suppression_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_valid (box_valid),
		.box_stall (box_stall),
		.box       (box),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Works out the verdict for one accepted box and moves the model on by it.
	// The IoU division is avoided: a box is suppressed when
	// inter * 256 > threshold * union, all in exact 64-bit arithmetic.
	function automatic res_word_t box_verdict(box_word_t b);
		int        ax, ay, aw, ah, lo, hi, ow, oh;
		longint    area_a, inter, uni;
		bit        keep;
		res_word_t v;
		ax     = $signed(b.box_x);
		ay     = $signed(b.box_y);
		aw     = int'(b.box_w);
		ah     = int'(b.box_h);
		area_a = longint'(aw) * longint'(ah);
		keep   = 1'b1;
		for (int i = 0; i < held_count && keep; i++) begin
			if (any_class || held[i].cls == b.class_id) begin
				// An empty or negative overlap on either axis gives no intersection.
				lo = (ax > held[i].x) ? ax : held[i].x;
				hi = (ax + aw < held[i].x + held[i].w) ? ax + aw : held[i].x + held[i].w;
				ow = (hi > lo) ? hi - lo : 0;
				lo = (ay > held[i].y) ? ay : held[i].y;
				hi = (ay + ah < held[i].y + held[i].h) ? ay + ah : held[i].y + held[i].h;
				oh = (hi > lo) ? hi - lo : 0;
				inter = longint'(ow) * longint'(oh);
				uni   = area_a + held[i].area - inter;
				if (inter * 256 > longint'(iou_limit) * uni)
					keep = 1'b0;
			end
		end
		// A kept box that finds the store full is still reported as kept.
		if (keep) begin
			if (held_count < MAX_KEPT) begin
				held[held_count] = '{x: ax, y: ay, w: aw, h: ah, cls: b.class_id,
					area: area_a};
				held_count++;
			end else begin
				store_full_seen = 1'b1;
			end
		end
		v.kept           = keep;
		v.kept_total     = KEPT_W'(held_count);
		v.store_overflow = store_full_seen;
		v.result_end     = b.set_end;
		// The last box of a set empties the store once its verdict is formed.
		if (b.set_end) begin
			held_count      = 0;
			store_full_seen = 1'b0;
		end
		return v;
	endfunction

	// Random box for a scene: mostly jittered around a few hubs so that boxes
	// of the same few classes overlap, with a share of wholly random words.
	function automatic box_word_t scene_box(logic last);
		box_word_t b;
		int        pick;
		if ($urandom_range(99) < 8) begin
			b.box_x    = COORD_W'($urandom);
			b.box_y    = COORD_W'($urandom);
			b.box_w    = SIZE_W'($urandom);
			b.box_h    = SIZE_W'($urandom);
			b.class_id = CLASS_W'($urandom);
		end else begin
			pick       = $urandom_range(3);
			b.box_x    = COORD_W'(hub_x[pick] + int'($urandom_range(800)) - 400);
			b.box_y    = COORD_W'(hub_y[pick] + int'($urandom_range(800)) - 400);
			b.box_w    = SIZE_W'($urandom_range(1600, 160));
			b.box_h    = SIZE_W'($urandom_range(1600, 160));
			b.class_id = ($urandom_range(9) == 0) ? CLASS_W'($urandom) :
				CLASS_W'($urandom_range(3));
			// Now and then a degenerate box with no area.
			if ($urandom_range(19) == 0)
				b.box_w = '0;
			else if ($urandom_range(19) == 0)
				b.box_h = '0;
		end
		b.set_end = last;
		return b;
	endfunction

	function automatic row_t box_row(int x, int y, int w, int h, int cls, bit last,
			bit known, bit k, int total);
		row_t r;
		r.kind  = ROW_BOX;
		r.word  = '{box_x: COORD_W'(x), box_y: COORD_W'(y), box_w: SIZE_W'(w),
			box_h: SIZE_W'(h), class_id: CLASS_W'(cls), set_end: last};
		r.known = known;
		r.want  = '{kept: k, kept_total: KEPT_W'(total), store_overflow: 1'b0,
			result_end: last};
		r.idx   = '0;
		r.data  = '0;
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		row_t r;
		r.kind  = ROW_REG;
		r.word  = '0;
		r.known = 1'b0;
		r.want  = '0;
		r.idx   = idx;
		r.data  = data;
		return r;
	endfunction

	// Appends one line to the end of the directed script.
	function automatic void add_row(row_t r);
		script = {script, r};
	endfunction

	// Offers one box word, idling at random first, and books its verdict once
	// the word has been taken. The valid stays high on return so that a
	// following word can go out back to back.
	task automatic send_box(input box_word_t w, input bit known, input res_word_t want);
		res_word_t forecast;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			box_valid <= 1'b0;
			@(posedge clk);
		end
		box_valid <= 1'b1;
		box       <= w;
		do @(posedge clk); while (box_stall !== 1'b0);
		forecast = box_verdict(w);
		verdicts = {verdicts, (known ? want : forecast)};
	endtask

	// Writes one register; the model follows the write once it is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_IOU_THRESHOLD)
			iou_limit = value[THR_W-1:0];
		else if (idx == REG_CLASS_AGNOSTIC)
			any_class = value[0];
	endtask

	// Holds the sender back until every owed verdict is in, then lets one more
	// full box time pass so that the block is surely idle.
	task automatic settle();
		box_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (verdicts.size() != 0)
			@(posedge clk);
		repeat (BOX_LATENCY) @(posedge clk);
	endtask

	// The receiver stalls at random; the rate drops to zero for one stretch.
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	// Compare every result word taken with the oldest verdict owed.
	always @(posedge clk) begin
		res_word_t due;
		if (res_valid === 1'b1 && res_stall === 1'b0) begin
			if (verdicts.size() == 0) begin
				$error("result word with no box outstanding");
				fault_count++;
			end else begin
				due = verdicts.pop_front();
				if (res.kept !== due.kept) begin
					$error("kept: expected %0d, got %0d", due.kept, res.kept);
					fault_count++;
				end
				if (res.kept_total !== due.kept_total) begin
					$error("kept_total: expected %0d, got %0d", due.kept_total,
						res.kept_total);
					fault_count++;
				end
				if (res.store_overflow !== due.store_overflow) begin
					$error("store_overflow: expected %0d, got %0d", due.store_overflow,
						res.store_overflow);
					fault_count++;
				end
				if (res.result_end !== due.result_end) begin
					$error("result_end: expected %0d, got %0d", due.result_end,
						res.result_end);
					fault_count++;
				end
			end
		end
	end

	// Count cycles in which no handshake of any kind completes.
	always @(posedge clk) begin
		if ((box_valid === 1'b1 && box_stall === 1'b0) ||
				(res_valid === 1'b1 && res_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL greedy_box_suppression_top");
		$finish;
	end

	initial begin : stimulus
		int   ph, sent, budget, set_len, thr;
		logic agn;

		// Directed cases, starting from the reset settings: threshold 115 and
		// class-aware comparison.
		add_row(box_row(0, 0, 160, 160, 3, 0, 1, 1, 1));
		// An exact duplicate of the same class is suppressed.
		add_row(box_row(0, 0, 160, 160, 3, 0, 1, 0, 1));
		// The same box under another class survives.
		add_row(box_row(0, 0, 160, 160, 4, 0, 1, 1, 2));
		// Disjoint, and then merely touching edges: no overlap at all.
		add_row(box_row(1000, 0, 160, 160, 3, 0, 1, 1, 3));
		add_row(box_row(160, 0, 160, 160, 3, 0, 1, 1, 4));
		// Two boxes with no area: the union is zero and nothing is suppressed.
		add_row(box_row(0, 0, 0, 0, 3, 0, 1, 1, 5));
		add_row(box_row(0, 0, 0, 0, 3, 0, 1, 1, 6));
		// The coordinate and size extremes.
		add_row(box_row(-32768, -32768, 32767, 32767, 127, 0, 1, 1, 7));
		add_row(box_row(-32768, -32768, 32767, 32767, 127, 0, 1, 0, 7));
		add_row(box_row(32767, 32767, 32767, 32767, 127, 0, 1, 1, 8));
		// A partial overlap close to the threshold, then the end of the set.
		add_row(box_row(80, 0, 160, 160, 3, 0, 0, 0, 0));
		add_row(box_row(4000, 4000, 16, 16, 0, 1, 0, 0, 0));
		// The store starts empty again after the end of a set.
		add_row(box_row(0, 0, 160, 160, 3, 0, 1, 1, 1));
		// Threshold zero: any overlap at all suppresses.
		add_row(reg_row(REG_IOU_THRESHOLD, CFG_DATA_W'(0)));
		add_row(box_row(150, 150, 160, 160, 3, 0, 1, 0, 1));
		add_row(box_row(0, 0, 160, 160, 5, 0, 1, 1, 2));
		// Class-agnostic mode; only the lowest data bit counts.
		add_row(reg_row(REG_CLASS_AGNOSTIC, '1));
		add_row(box_row(8, 8, 160, 160, 9, 0, 1, 0, 2));
		// At 256 even an exact duplicate is not suppressed, nor above 256.
		add_row(reg_row(REG_IOU_THRESHOLD, CFG_DATA_W'(256)));
		add_row(box_row(0, 0, 160, 160, 11, 0, 1, 1, 3));
		add_row(reg_row(REG_IOU_THRESHOLD, CFG_DATA_W'(511)));
		add_row(box_row(0, 0, 160, 160, 11, 0, 1, 1, 4));
		// A write to an unused index leaves both registers alone.
		add_row(reg_row(REG_SPARE, '1));
		add_row(box_row(0, 0, 160, 160, 11, 1, 1, 1, 5));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_REG) begin
				settle();
				write_reg(script[r].idx, script[r].data);
			end else begin
				send_box(script[r].word, script[r].known, script[r].want);
			end
		end

		// Random scenes, one register setting per phase. Phase two fills the
		// store past capacity at a threshold that can suppress nothing, and
		// phase four runs with neither side idling.
		for (ph = 0; ph < 7; ph++) begin
			settle();
			idle_pct  = (ph == 4) ? 0 : 31;
			stall_pct = (ph == 4) ? 0 : 31;
			case (ph)
				0: begin thr = 115; agn = 1'b0; end
				1: begin thr = 0;   agn = 1'b1; end
				2: begin thr = 256; agn = 1'b1; end
				3: begin thr = 511; agn = 1'b0; end
				4: begin thr = 200; agn = 1'b1; end
				5: begin thr = 60;  agn = 1'b0; end
				default: begin
					thr = $urandom_range(511);
					agn = 1'($urandom);
				end
			endcase
			write_reg(REG_IOU_THRESHOLD, CFG_DATA_W'(thr));
			write_reg(REG_CLASS_AGNOSTIC, {(CFG_DATA_W-1)'($urandom), agn});
			sent   = 0;
			budget = (ph == 2) ? 300 : 170;
			while (sent < budget) begin
				foreach (hub_x[i]) begin
					hub_x[i] = int'($urandom_range(40000)) - 20000;
					hub_y[i] = int'($urandom_range(40000)) - 20000;
				end
				set_len = (ph == 2 && sent == 0) ? MAX_KEPT + 6 : $urandom_range(30, 1);
				if (set_len > budget - sent)
					set_len = budget - sent;
				for (int k = 0; k < set_len; k++) begin
					// Part way into each phase the sender waits for the block
					// to drain completely before carrying on with the set.
					if (sent == 20)
						settle();
					send_box(scene_box(k == set_len - 1), 1'b0, '0);
					sent++;
				end
			end
		end

		settle();
		if (fault_count == 0)
			$display("PASS greedy_box_suppression_top");
		else
			$display("FAIL greedy_box_suppression_top");
		$finish;
	end

endmodule : greedy_box_suppression_top_tb
`default_nettype wire
